/* hw/rtl/scpc_pkg.sv */
// Shared constants and control/status types of the segment crossing pair counter.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package scpc_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COUNT_BITS     = 19;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_Y = 2'd3;

  typedef struct packed {
    logic load;
    logic issue;
    logic issue_self;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic none;
    logic last_pair;
  } sts_t;

endpackage

/* hw/rtl/scpc_ifs.sv */
// Channel interfaces: point requests, pair count results and configuration writes.
// Depends on scpc_pkg for default widths.
`timescale 1ns / 1ps

interface scpc_pt_if #(
  parameter int COORD_BITS = scpc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         is_last;

  modport source (output valid, point_x, point_y, is_last, input ready);
  modport sink   (input valid, point_x, point_y, is_last, output ready);
endinterface

interface scpc_cnt_if;
  logic                              valid;
  logic                              ready;
  logic [scpc_pkg::COUNT_BITS-1:0]   pair_count;

  modport source (output valid, pair_count, input ready);
  modport sink   (input valid, pair_count, output ready);
endinterface

interface scpc_cfg_if #(
  parameter int COORD_BITS = scpc_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [scpc_pkg::CFG_IDX_BITS-1:0] index;
  logic signed [COORD_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/scpc_ctrl.sv */
// Sequencer of the pair counter: accept, self pass, pair sweep, drain, result.
// Depends on scpc_pkg for the command and status types.
`timescale 1ns / 1ps

module scpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  scpc_pkg::sts_t sts,
  output scpc_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SELF  = 3'd1;
  localparam logic [2:0] ST_PAIR  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SELF;
        end
      end
      ST_SELF: begin
        cmd.issue      = 1'b1;
        cmd.issue_self = 1'b1;
        state_nxt      = sts.none ? ST_DRAIN : ST_PAIR;
      end
      ST_PAIR: begin
        cmd.issue = 1'b1;
        if (sts.last_pair) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = sts.last ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/scpc_dpath.sv */
// Datapath of the pair counter: configuration, point memory, four-stage pair test
// pipeline and saturating pair count. Depends on scpc_pkg.
`timescale 1ns / 1ps

module scpc_dpath #(
  parameter int MAX_POINTS = scpc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = scpc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scpc_pkg::cmd_t                    cmd,
  output scpc_pkg::sts_t                    sts,
  input  logic signed [COORD_BITS-1:0]      point_x,
  input  logic signed [COORD_BITS-1:0]      point_y,
  input  logic                              is_last,
  input  logic                              cfg_we,
  input  logic [scpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic signed [COORD_BITS-1:0]      cfg_data,
  output logic [scpc_pkg::COUNT_BITS-1:0]   pair_count
);

  localparam int R  = COORD_BITS + 1;
  localparam int D  = COORD_BITS + 2;
  localparam int P  = 2 * D;
  localparam int S  = P + 1;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int FW = $clog2(MAX_POINTS + 1);
  localparam int CB = scpc_pkg::COUNT_BITS;

  function automatic logic opp(input logic signed [D-1:0] a, input logic signed [D-1:0] b);
    return ((a < 0) && (b > 0)) || ((a > 0) && (b < 0));
  endfunction

  // configuration
  logic signed [COORD_BITS-1:0] ox_r, oy_r, tx_r, ty_r;

  // current request
  logic signed [R-1:0] bx_r, by_r, lx_r, ly_r;
  logic signed [R-1:0] bx_nxt, by_nxt;
  logic [FW-1:0]       n_r, fill_r, idx_r;
  logic                last_r;

  // point memory
  logic [2*R-1:0] mem [MAX_POINTS];
  logic [2*R-1:0] mem_rd_r;

  // stage 1
  logic s1_valid_r, s1_self_r;
  logic signed [R-1:0] ax, ay;
  logic signed [D-1:0] axd, ayd, bxd, byd, lxd, lyd, dax, day, dbx, dby;

  // stage 2
  logic signed [P-1:0] prod_nxt [10];
  logic signed [P-1:0] prod_r   [10];
  logic s2_valid_r, s2_self_r, s2_opp_o_r, s2_opp_l_r;

  // stage 3
  logic signed [S-1:0] sum_la, sum_dot, sum_dotl, sum_ab, sum_abl;
  logic s3_valid_r, s3_self_r, s3_opp_o_r, s3_opp_l_r;
  logic s3_la_neg_r, s3_la_zero_r, s3_dot_neg_r, s3_dot_zero_r, s3_dotl_neg_r;
  logic s3_ab_neg_r, s3_ab_zero_r, s3_abl_neg_r, s3_abl_zero_r;

  // stage 4
  logic b_la_neg_r, b_la_zero_r, b_in_ol_r;
  logic in_ol_a, cross_l, cross_ab, meets;
  logic [CB-1:0] count_r, out_count_r;

  assign bx_nxt = R'(point_x) - R'(ox_r);
  assign by_nxt = R'(point_y) - R'(oy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      tx_r <= '0;
      ty_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        scpc_pkg::CFG_ORIGIN_X: ox_r <= cfg_data;
        scpc_pkg::CFG_ORIGIN_Y: oy_r <= cfg_data;
        scpc_pkg::CFG_TARGET_X: tx_r <= cfg_data;
        scpc_pkg::CFG_TARGET_Y: ty_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      lx_r   <= R'(tx_r) - R'(ox_r);
      ly_r   <= R'(ty_r) - R'(oy_r);
      n_r    <= fill_r;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (fill_r < FW'(MAX_POINTS))) begin
      mem[fill_r[AW-1:0]] <= {bx_nxt, by_nxt};
    end
    if (cmd.issue && !cmd.issue_self) begin
      mem_rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  // stage 1: pick the stored point, or the new point itself on the self pass
  assign ax  = s1_self_r ? bx_r : $signed(mem_rd_r[2*R-1:R]);
  assign ay  = s1_self_r ? by_r : $signed(mem_rd_r[R-1:0]);
  assign axd = D'(ax);
  assign ayd = D'(ay);
  assign bxd = D'(bx_r);
  assign byd = D'(by_r);
  assign lxd = D'(lx_r);
  assign lyd = D'(ly_r);
  assign dax = axd - lxd;
  assign day = ayd - lyd;
  assign dbx = bxd - lxd;
  assign dby = byd - lyd;

  always_comb begin
    prod_nxt[0] = lxd * ayd;
    prod_nxt[1] = lyd * axd;
    prod_nxt[2] = axd * lxd;
    prod_nxt[3] = ayd * lyd;
    prod_nxt[4] = dax * lxd;
    prod_nxt[5] = day * lyd;
    prod_nxt[6] = axd * byd;
    prod_nxt[7] = ayd * bxd;
    prod_nxt[8] = dax * dby;
    prod_nxt[9] = day * dbx;
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    s2_self_r  <= s1_self_r;
    s2_opp_o_r <= opp(axd, bxd) || opp(ayd, byd);
    s2_opp_l_r <= opp(dax, dbx) || opp(day, dby);
  end

  // stage 3: signs of the cross and dot products
  assign sum_la   = S'(prod_r[0]) - S'(prod_r[1]);
  assign sum_dot  = S'(prod_r[2]) + S'(prod_r[3]);
  assign sum_dotl = S'(prod_r[4]) + S'(prod_r[5]);
  assign sum_ab   = S'(prod_r[6]) - S'(prod_r[7]);
  assign sum_abl  = S'(prod_r[8]) - S'(prod_r[9]);

  always_ff @(posedge clk) begin
    s3_self_r     <= s2_self_r;
    s3_opp_o_r    <= s2_opp_o_r;
    s3_opp_l_r    <= s2_opp_l_r;
    s3_la_neg_r   <= sum_la[S-1];
    s3_la_zero_r  <= (sum_la == '0);
    s3_dot_neg_r  <= sum_dot[S-1];
    s3_dot_zero_r <= (sum_dot == '0);
    s3_dotl_neg_r <= sum_dotl[S-1];
    s3_ab_neg_r   <= sum_ab[S-1];
    s3_ab_zero_r  <= (sum_ab == '0);
    s3_abl_neg_r  <= sum_abl[S-1];
    s3_abl_zero_r <= (sum_abl == '0);
  end

  // stage 4: combine and count
  assign in_ol_a  = s3_la_zero_r && !s3_dot_neg_r && !s3_dot_zero_r && s3_dotl_neg_r;
  assign cross_l  = !s3_la_zero_r && !b_la_zero_r && (s3_la_neg_r != b_la_neg_r);
  assign cross_ab = !s3_ab_zero_r && !s3_abl_zero_r && (s3_ab_neg_r != s3_abl_neg_r);
  assign meets    = (cross_l && cross_ab) || in_ol_a || b_in_ol_r
                 || (s3_ab_zero_r && s3_opp_o_r) || (s3_abl_zero_r && s3_opp_l_r);

  always_ff @(posedge clk) begin
    if (s3_valid_r && s3_self_r) begin
      b_la_neg_r  <= s3_la_neg_r;
      b_la_zero_r <= s3_la_zero_r;
      b_in_ol_r   <= in_ol_a;
    end
    if (cmd.finish) begin
      out_count_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_self_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      fill_r     <= '0;
      idx_r      <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= cmd.issue;
      s1_self_r  <= cmd.issue_self;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (cmd.issue) begin
        idx_r <= cmd.issue_self ? '0 : idx_r + FW'(1);
      end
      if (cmd.finish) begin
        fill_r  <= '0;
        count_r <= '0;
      end else begin
        if (cmd.load && (fill_r < FW'(MAX_POINTS))) begin
          fill_r <= fill_r + FW'(1);
        end
        if (s3_valid_r && !s3_self_r && meets && (count_r != '1)) begin
          count_r <= count_r + CB'(1);
        end
      end
    end
  end

  assign sts.busy      = s1_valid_r || s2_valid_r || s3_valid_r;
  assign sts.last      = last_r;
  assign sts.none      = (n_r == '0);
  assign sts.last_pair = ((idx_r + FW'(1)) == n_r);
  assign pair_count    = out_count_r;

endmodule

/* hw/rtl/segment_crossing_pair_counter_unit.sv */
// Segment crossing pair counter: each point request is tested against every stored point.
// The result of a set is valid after the self pass of its last point, a sweep over the n points
// stored in the set so far (at most MAX_POINTS) and the pipeline drain; one stored point is
// compared per cycle through the memory read port. The next request is accepted only once the
// previous one has drained and, after the last point of a set, any earlier result has been taken.
// Reset (synchronous, rst_n low) clears configuration, fill level, count and pipeline.
`timescale 1ns / 1ps

module segment_crossing_pair_counter_unit #(
  parameter int MAX_POINTS = scpc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = scpc_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  scpc_pt_if.sink      in_pt,
  scpc_cnt_if.source   out_cnt,
  scpc_cfg_if.sink     cfg_wr
);

  scpc_pkg::cmd_t cmd;
  scpc_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  scpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_cnt.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scpc_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .point_x    (in_pt.point_x),
    .point_y    (in_pt.point_y),
    .is_last    (in_pt.is_last),
    .cfg_we     (cfg_wr.valid),
    .cfg_index  (cfg_wr.index),
    .cfg_data   (cfg_wr.data),
    .pair_count (out_cnt.pair_count)
  );

  assign in_pt.ready   = in_ready;
  assign out_cnt.valid = out_valid;
  assign cfg_wr.ready  = 1'b1;

  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    in_pt.ready |-> !sts.busy)
    else $error("request accepted while pair pipeline busy");

  a_self_first : assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> (cmd.issue && cmd.issue_self))
    else $error("self pass did not follow accepted request");

  a_pair_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && !cmd.issue_self) |-> !sts.none)
    else $error("pair issued with empty store");

  a_finish_out : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_cnt.valid && !sts.busy))
    else $error("result not presented after finish");

endmodule

/* tb/segment_crossing_pair_counter_unit_tb.sv */
// Testbench for segment_crossing_pair_counter_unit: randomized point sets against an in-bench
// pair-count predictor, with degenerate and vertical segments and mid-set register changes.
// Depends on scpc_pkg, the scpc channel interfaces and the unit itself.
`timescale 1ns / 1ps

module segment_crossing_pair_counter_unit_tb;

  localparam int          MAX_PTS     = scpc_pkg::MAX_POINTS_DEF;
  localparam int          CRD_BITS    = scpc_pkg::COORD_BITS_DEF;
  localparam longint      COORD_MIN   = -(longint'(1) << (CRD_BITS - 1));
  localparam longint      COORD_MAX   = (longint'(1) << (CRD_BITS - 1)) - 1;
  localparam int unsigned COUNT_SAT   = (1 << scpc_pkg::COUNT_BITS) - 1;
  localparam int          DRAIN_WAIT  = MAX_PTS + 16;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int          RAND_ITEMS  = 560;

  typedef logic signed [CRD_BITS-1:0] coord_t;

  class pair_count_tracker;
    longint                          org_x = 0, org_y = 0, tgt_x = 0, tgt_y = 0;
    longint                          held_x[MAX_PTS];
    longint                          held_y[MAX_PTS];
    int unsigned                     held_n = 0;
    int unsigned                     tally = 0;
    logic [scpc_pkg::COUNT_BITS-1:0] due_counts[$];
    int unsigned                     fails = 0;

    function void apply_reg(logic [scpc_pkg::CFG_IDX_BITS-1:0] idx, coord_t val);
      case (idx)
        scpc_pkg::CFG_ORIGIN_X: org_x = val;
        scpc_pkg::CFG_ORIGIN_Y: org_y = val;
        scpc_pkg::CFG_TARGET_X: tgt_x = val;
        default:                tgt_y = val;
      endcase
    endfunction

    function int sg(longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    // P strictly between the origin and L, both relative to the origin
    function bit on_ol(longint px, longint py, longint lx, longint ly);
      if (lx * py - ly * px != 0) return 1'b0;
      if (px * lx + py * ly <= 0) return 1'b0;
      return (px - lx) * lx + (py - ly) * ly < 0;
    endfunction

    // Q strictly between A and B
    function bit on_ab(longint qx, longint qy, longint ax, longint ay,
                       longint bx, longint by);
      if ((ax - qx) * (by - qy) - (ay - qy) * (bx - qx) != 0) return 1'b0;
      return sg(ax - qx) * sg(bx - qx) < 0 || sg(ay - qy) * sg(by - qy) < 0;
    endfunction

    function bit meets(longint ax, longint ay, longint bx, longint by,
                       longint lx, longint ly);
      int s11, s12, s21, s22;
      s11 = sg(lx * ay - ly * ax);
      s12 = sg(lx * by - ly * bx);
      s21 = sg((by - ay) * ax - (bx - ax) * ay);
      s22 = sg((bx - ax) * (ly - ay) - (by - ay) * (lx - ax));
      if (s11 * s12 < 0 && s21 * s22 < 0) return 1'b1;
      if (on_ol(ax, ay, lx, ly) || on_ol(bx, by, lx, ly)) return 1'b1;
      return on_ab(0, 0, ax, ay, bx, by) || on_ab(lx, ly, ax, ay, bx, by);
    endfunction

    function void note_point(coord_t px, coord_t py, logic last);
      longint bx, by, lx, ly;
      bx = longint'(px) - org_x;
      by = longint'(py) - org_y;
      lx = tgt_x - org_x;
      ly = tgt_y - org_y;
      for (int i = 0; i < held_n; i++) begin
        if (meets(held_x[i], held_y[i], bx, by, lx, ly) && tally < COUNT_SAT) tally++;
      end
      if (held_n < MAX_PTS) begin
        held_x[held_n] = bx;
        held_y[held_n] = by;
        held_n++;
      end
      if (last) begin
        due_counts.insert(due_counts.size(), tally[scpc_pkg::COUNT_BITS-1:0]);
        held_n = 0;
        tally  = 0;
      end
    endfunction

    function void check_count(logic [scpc_pkg::COUNT_BITS-1:0] got);
      logic [scpc_pkg::COUNT_BITS-1:0] want;
      if (due_counts.size() == 0) begin
        fails++;
        if (fails <= 10) $display("pair_count %0d arrived with none pending", got);
        return;
      end
      want = due_counts.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) $display("pair_count error: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  int unsigned       cycle_cnt = 0;
  int                in_gap_mode;
  longint            cur_ox, cur_oy, cur_tx, cur_ty, step_x, step_y, nsteps;
  pair_count_tracker tracker;

  scpc_pt_if  in_pt ();
  scpc_cnt_if out_cnt ();
  scpc_cfg_if cfg_wr ();

  segment_crossing_pair_counter_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_pt),
    .out_cnt (out_cnt),
    .cfg_wr  (cfg_wr)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("segment_crossing_pair_counter_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_wr.valid && cfg_wr.ready) tracker.apply_reg(cfg_wr.index, cfg_wr.data);
      if (out_cnt.valid && out_cnt.ready) tracker.check_count(out_cnt.pair_count);
      if (in_pt.valid && in_pt.ready)
        tracker.note_point(in_pt.point_x, in_pt.point_y, in_pt.is_last);
    end
  end

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic coord_t to_coord(longint v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic longint pick_edge();
    case ($urandom_range(0, 6))
      0:       return COORD_MIN;
      1:       return COORD_MIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return COORD_MAX - 1;
      default: return COORD_MAX;
    endcase
  endfunction

  function automatic int pick_gap(int lo_cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < lo_cap) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // result side: random stalls, mostly short, with long stall-free stretches
  initial begin : count_sink
    int stall, run;
    forever begin
      stall = pick_gap(50);
      run   = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 4);
      if (stall > 0) begin
        out_cnt.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_cnt.ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_point(longint x, longint y, logic last);
    int gap;
    gap = (in_gap_mode != 0) ? pick_gap(50) : 0;
    if (gap > 0) begin
      in_pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pt.valid   <= 1'b1;
    in_pt.point_x <= to_coord(x);
    in_pt.point_y <= to_coord(y);
    in_pt.is_last <= last;
    do @(posedge clk); while (!in_pt.ready);
  endtask

  task automatic wait_drained();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_counts.size() != 0) @(posedge clk);
  endtask

  // hold until the pipeline is empty, including points that produce no count
  task automatic settle();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_reg(logic [scpc_pkg::CFG_IDX_BITS-1:0] idx, longint val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= to_coord(val);
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(longint ox, longint oy, longint tx, longint ty);
    cur_ox = to_coord(ox);
    cur_oy = to_coord(oy);
    cur_tx = to_coord(tx);
    cur_ty = to_coord(ty);
    load_reg(scpc_pkg::CFG_ORIGIN_X, cur_ox);
    load_reg(scpc_pkg::CFG_ORIGIN_Y, cur_oy);
    load_reg(scpc_pkg::CFG_TARGET_X, cur_tx);
    load_reg(scpc_pkg::CFG_TARGET_Y, cur_ty);
    step_x = (cur_tx - cur_ox) / 2;
    step_y = (cur_ty - cur_oy) / 2;
    nsteps = 2;
  endtask

  task automatic gen_point(output longint x, output longint y);
    longint j, span;
    case ($urandom_range(0, 9))
      0, 1: begin
        x = rnd(COORD_MIN, COORD_MAX);
        y = rnd(COORD_MIN, COORD_MAX);
      end
      2, 3, 4: begin
        j = rnd(-2, nsteps + 2);
        x = cur_ox + j * step_x;
        y = cur_oy + j * step_y;
        if ($urandom_range(0, 4) == 0) begin
          x = x + rnd(-1, 1);
          y = y + rnd(-1, 1);
        end
      end
      5: begin
        x = cur_ox + rnd(-4, 4);
        y = cur_oy + rnd(-4, 4);
      end
      6: begin
        x = cur_tx + rnd(-4, 4);
        y = cur_ty + rnd(-4, 4);
      end
      7, 8: begin
        span = longint'(1) << rnd(1, 20);
        x = (cur_ox + cur_tx) / 2 + rnd(-span, span);
        y = (cur_oy + cur_ty) / 2 + rnd(-span, span);
      end
      default: begin
        x = pick_edge();
        y = pick_edge();
      end
    endcase
  endtask

  task automatic random_cfg();
    longint ox, oy, sx, sy, ns;
    ox = rnd(COORD_MIN, COORD_MAX);
    oy = rnd(COORD_MIN, COORD_MAX);
    case ($urandom_range(0, 4))
      0: set_cfg(ox, oy, rnd(COORD_MIN, COORD_MAX), rnd(COORD_MIN, COORD_MAX));
      1: begin
        ox = rnd(-1040000, 1040000);
        oy = rnd(-1040000, 1040000);
        sx = rnd(-3, 3);
        sy = rnd(-3, 3);
        ns = rnd(0, 4);
        set_cfg(ox, oy, ox + ns * sx, oy + ns * sy);
        step_x = sx;
        step_y = sy;
        nsteps = ns;
      end
      2: set_cfg(pick_edge(), pick_edge(), pick_edge(), pick_edge());
      3: set_cfg(ox, oy, ox, oy);
      default: begin
        if ($urandom_range(0, 1) == 0) set_cfg(ox, oy, ox, rnd(COORD_MIN, COORD_MAX));
        else set_cfg(ox, oy, rnd(COORD_MIN, COORD_MAX), oy);
      end
    endcase
  endtask

  initial begin : stimulus
    int     sent, nsets, size;
    longint px, py;

    tracker        = new();
    in_gap_mode    = 1;
    rst_n         <= 1'b0;
    in_pt.valid   <= 1'b0;
    in_pt.point_x <= '0;
    in_pt.point_y <= '0;
    in_pt.is_last <= 1'b0;
    cfg_wr.valid  <= 1'b0;
    cfg_wr.index  <= scpc_pkg::CFG_ORIGIN_X;
    cfg_wr.data   <= '0;
    cur_ox = 0; cur_oy = 0; cur_tx = 0; cur_ty = 0;
    step_x = 0; step_y = 0; nsteps = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate OL at reset: only the origin-inside-AB test can count
    send_point(-5, 0, 1'b0);
    send_point(5, 0, 1'b1);
    send_point(7, 7, 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(3, 3, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);

    settle();
    set_cfg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);

    // vertical OL, then move the origin in the middle of the set
    settle();
    set_cfg(10, -20, 10, 40);
    send_point(10, 0, 1'b0);
    send_point(50, 5, 1'b0);
    send_point(-30, 5, 1'b0);
    send_point(10, 40, 1'b0);
    settle();
    load_reg(scpc_pkg::CFG_ORIGIN_X, 12);
    send_point(10, 100, 1'b0);
    send_point(10, -50, 1'b1);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle();
      in_gap_mode = ($urandom_range(0, 3) != 0);
      random_cfg();
      nsets = $urandom_range(1, 4);
      for (int s = 0; s < nsets; s++) begin
        if ($urandom_range(0, 9) == 0) wait_drained();
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
        for (int k = 0; k < size; k++) begin
          if (k > 0 && k == size / 2 && $urandom_range(0, 19) == 0) begin
            settle();
            load_reg(scpc_pkg::CFG_IDX_BITS'($urandom_range(0, 3)),
                     rnd(COORD_MIN, COORD_MAX));
          end
          gen_point(px, py);
          send_point(px, py, k == size - 1);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.fails == 0 && tracker.due_counts.size() == 0)
      $display("segment_crossing_pair_counter_unit: match");
    else
      $display("segment_crossing_pair_counter_unit: mismatch");
    $finish;
  end

endmodule
